/* rtl/core/two_level_page_table_walker_core_assert.svh */
// ----------------------------------------------------------------------------
// Page table walker assertion macros
// Shared concurrent assertion forms used by the walker RTL.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_PAGE_TABLE_WALKER_CORE_ASSERT_SVH
`define TWO_LEVEL_PAGE_TABLE_WALKER_CORE_ASSERT_SVH

// check on every clock edge outside reset
`define TLPW_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// check on every clock edge, reset included
`define TLPW_ASSERT_NR(name, prop, msg) \
  name: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

/* rtl/core/tlpw_pkg.sv */
// ----------------------------------------------------------------------------
// Page table walker package
// Types, codes and helpers shared by the walker modules.
// ----------------------------------------------------------------------------
package tlpw_pkg;

  localparam int MAX_RESULTS  = 3;
  localparam int BIT_PRESENT  = 0;
  localparam int BIT_ACCESSED = 5;
  localparam int BIT_DIRTY    = 6;

  localparam logic [12:0] PAGE_BYTES = 13'd4096;

  localparam logic ACT_TRANSLATE = 1'b0;
  localparam logic ACT_RESPONSE  = 1'b1;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  localparam logic [1:0] STATUS_OK           = 2'd0;
  localparam logic [1:0] STATUS_CROSS        = 2'd1;
  localparam logic [1:0] STATUS_DIR_ABSENT   = 2'd2;
  localparam logic [1:0] STATUS_TABLE_ABSENT = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_DIR   = 2'd1,
    PH_TABLE = 2'd2
  } walk_phase_t;

  typedef struct packed {
    logic        action;
    logic [31:0] virt_addr;
    logic        access_is_write;
    logic [3:0]  access_len;
    logic [31:0] mem_read_data;
  } item_t;

  typedef struct packed {
    walk_phase_t phase;
    logic [9:0]  dir_index;
    logic [9:0]  table_index;
    logic        write_pending;
    logic [31:0] dir_entry;
  } walk_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] mem_addr;
    logic [31:0] mem_write_data;
    logic [19:0] phys_frame;
    logic [1:0]  status;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0]                    count;
    result_t [MAX_RESULTS-1:0]     res;
  } batch_t;

  function automatic result_t make_result(input logic [1:0] kind, input logic [31:0] addr,
                                          input logic [31:0] data, input logic [19:0] frame,
                                          input logic [1:0] status);
    result_t r;
    r.kind           = kind;
    r.mem_addr       = addr;
    r.mem_write_data = data;
    r.phys_frame     = frame;
    r.status         = status;
    r.last           = 1'b0;
    return r;
  endfunction

endpackage

/* rtl/core/tlpw_step.sv */
// ----------------------------------------------------------------------------
// Page table walker step logic
// Applies one request to the walk state and forms its batch of results.
// ----------------------------------------------------------------------------
module tlpw_step import tlpw_pkg::*; (
  input  walk_t       walk,
  input  logic [19:0] dir_frame,
  input  item_t       item,
  output walk_t       walk_next,
  output batch_t      batch
);

  always_comb begin
    logic [12:0] end_off;
    logic [31:0] de_addr;
    logic [31:0] pte_addr;
    logic [31:0] pte;
    logic [31:0] pte_upd_word;
    logic [1:0]  n;
    logic        dir_upd;
    logic        pte_upd;

    walk_next = walk;
    batch     = '0;
    n         = 2'd0;
    end_off   = {1'b0, item.virt_addr[11:0]} + {9'd0, item.access_len};
    de_addr   = {dir_frame, walk.dir_index, 2'b00};
    pte       = item.mem_read_data;
    pte_addr  = {walk.dir_entry[31:12], walk.table_index, 2'b00};
    dir_upd   = !walk.dir_entry[BIT_ACCESSED];
    pte_upd   = !pte[BIT_ACCESSED] || (!pte[BIT_DIRTY] && walk.write_pending);
    pte_upd_word = pte;
    pte_upd_word[BIT_ACCESSED] = 1'b1;
    pte_upd_word[BIT_DIRTY]    = pte[BIT_DIRTY] | walk.write_pending;

    if (item.action == ACT_TRANSLATE) begin
      if (end_off > PAGE_BYTES) begin
        walk_next.phase = PH_IDLE;
        batch.res[0] = make_result(KIND_DONE, '0, '0, '0, STATUS_CROSS);
        n = 2'd1;
      end else begin
        walk_next.dir_index     = item.virt_addr[31:22];
        walk_next.table_index   = item.virt_addr[21:12];
        walk_next.write_pending = item.access_is_write;
        walk_next.phase         = PH_DIR;
        batch.res[0] = make_result(KIND_READ, {dir_frame, item.virt_addr[31:22], 2'b00},
                                   '0, '0, STATUS_OK);
        n = 2'd1;
      end
    end else begin
      unique case (walk.phase)
        PH_DIR: begin
          walk_next.dir_entry = item.mem_read_data;
          if (!item.mem_read_data[BIT_PRESENT]) begin
            walk_next.phase = PH_IDLE;
            batch.res[0] = make_result(KIND_DONE, '0, '0, '0, STATUS_DIR_ABSENT);
          end else begin
            walk_next.phase = PH_TABLE;
            batch.res[0] = make_result(KIND_READ,
                                       {item.mem_read_data[31:12], walk.table_index, 2'b00},
                                       '0, '0, STATUS_OK);
          end
          n = 2'd1;
        end
        PH_TABLE: begin
          walk_next.phase = PH_IDLE;
          if (!pte[BIT_PRESENT]) begin
            batch.res[0] = make_result(KIND_DONE, '0, '0, '0, STATUS_TABLE_ABSENT);
            n = 2'd1;
          end else begin
            if (dir_upd) begin
              batch.res[n] = make_result(KIND_WRITE, de_addr,
                                         walk.dir_entry | 32'h0000_0020, '0, STATUS_OK);
              n = n + 2'd1;
            end
            if (pte_upd) begin
              batch.res[n] = make_result(KIND_WRITE, pte_addr, pte_upd_word, '0, STATUS_OK);
              n = n + 2'd1;
            end
            batch.res[n] = make_result(KIND_DONE, '0, '0, pte[31:12], STATUS_OK);
            n = n + 2'd1;
          end
        end
        default: begin
          walk_next.phase = PH_IDLE;
        end
      endcase
    end

    batch.count = n;
    if (n != 2'd0) begin
      batch.res[n - 2'd1].last = 1'b1;
    end
  end

endmodule

/* rtl/core/tlpw_rbuf.sv */
// ----------------------------------------------------------------------------
// Page table walker result buffer
// Holds one request's batch of results and hands them out in order.
// ----------------------------------------------------------------------------
`include "two_level_page_table_walker_core_assert.svh"

module tlpw_rbuf import tlpw_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  batch_t  batch,
  input  logic    out_stall,
  output logic    free,
  output logic    out_valid,
  output result_t out_res
);

  result_t [MAX_RESULTS-1:0] ent;
  logic [1:0] n;
  logic [1:0] ptr;
  logic       at_last;

  assign out_valid = (n != 2'd0);
  assign out_res   = ent[ptr];
  assign at_last   = (ptr == n - 2'd1);
  assign free      = !out_valid || (!out_stall && at_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      n   <= 2'd0;
      ptr <= 2'd0;
    end else if (load) begin
      n   <= batch.count;
      ptr <= 2'd0;
    end else if (out_valid && !out_stall) begin
      if (at_last) begin
        n   <= 2'd0;
        ptr <= 2'd0;
      end else begin
        ptr <= ptr + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ent <= batch.res;
    end
  end

  `TLPW_ASSERT(a_ptr_in_batch, out_valid |-> ptr < n, "result pointer past batch end")
  `TLPW_ASSERT(a_last_not_write, out_valid && out_res.last |-> out_res.kind != KIND_WRITE,
    "batch ends in a write request")
  `TLPW_ASSERT(a_empty_batch, load && batch.count == 2'd0 |=> !out_valid,
    "empty batch shows a result")

endmodule

/* rtl/core/two_level_page_table_walker_core.sv */
// ----------------------------------------------------------------------------
// Two-level page table walker core
// Channel  | Direction | Handshake          | Payload
// in       | input     | in_valid/in_stall  | action, virt_addr, access_is_write,
//          |           |                    | access_len, mem_read_data
// out      | output    | out_valid/out_stall| result_kind, mem_addr, mem_write_data,
//          |           |                    | phys_frame, status, last
// cfg      | input     | cfg_valid/cfg_ready| page_dir_frame
// A request moves input register -> step logic -> result buffer; its first result
// is valid once the result buffer has loaded it. A request giving k results (zero to
// three) holds the result buffer until all k have left, so one request per cycle
// while each gives a single result and the output is not stalled. Synchronous reset
// idles the walk. A stalled output holds the buffer and in turn stalls the input.
// ----------------------------------------------------------------------------
`include "two_level_page_table_walker_core_assert.svh"

module two_level_page_table_walker_core import tlpw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [19:0] page_dir_frame,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [31:0] virt_addr,
  input  logic        access_is_write,
  input  logic [3:0]  access_len,
  input  logic [31:0] mem_read_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [31:0] mem_addr,
  output logic [31:0] mem_write_data,
  output logic [19:0] phys_frame,
  output logic [1:0]  status,
  output logic        last
);

  logic [19:0] dir_frame;
  logic        ir_valid;
  item_t       ir;
  item_t       item_in;
  walk_t       walk;
  walk_t       walk_next;
  batch_t      batch;
  result_t     out_res;
  logic        buf_free;
  logic        load;

  assign cfg_ready = 1'b1;
  assign item_in   = '{action: action, virt_addr: virt_addr,
                       access_is_write: access_is_write, access_len: access_len,
                       mem_read_data: mem_read_data};
  assign load      = ir_valid && buf_free;
  assign in_stall  = ir_valid && !buf_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      dir_frame          <= '0;
      ir_valid           <= 1'b0;
      walk.phase         <= PH_IDLE;
      walk.dir_index     <= '0;
      walk.table_index   <= '0;
      walk.write_pending <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        dir_frame <= page_dir_frame;
      end
      if (in_valid && !in_stall) begin
        ir_valid <= 1'b1;
      end else if (load) begin
        ir_valid <= 1'b0;
      end
      if (load) begin
        walk.phase         <= walk_next.phase;
        walk.dir_index     <= walk_next.dir_index;
        walk.table_index   <= walk_next.table_index;
        walk.write_pending <= walk_next.write_pending;
        walk.dir_entry     <= walk_next.dir_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ir <= item_in;
    end
  end

  tlpw_step u_step (
    .walk      (walk),
    .dir_frame (dir_frame),
    .item      (ir),
    .walk_next (walk_next),
    .batch     (batch)
  );

  tlpw_rbuf u_rbuf (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .batch     (batch),
    .out_stall (out_stall),
    .free      (buf_free),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign result_kind    = out_res.kind;
  assign mem_addr       = out_res.mem_addr;
  assign mem_write_data = out_res.mem_write_data;
  assign phys_frame     = out_res.phys_frame;
  assign status         = out_res.status;
  assign last           = out_res.last;

  `TLPW_ASSERT(a_hold_request, ir_valid && !load |=> ir_valid && $stable(ir),
    "held request lost or changed")
  `TLPW_ASSERT(a_table_ends_walk,
    load && ir.action == ACT_RESPONSE && walk.phase == PH_TABLE |=> walk.phase == PH_IDLE,
    "walk not idle after table entry")
  `TLPW_ASSERT(a_fault_is_done, out_valid && status != STATUS_OK |-> result_kind == KIND_DONE,
    "fault status on a memory request")
  `TLPW_ASSERT_NR(a_reset_empty, rst |=> !ir_valid && !out_valid,
    "pipeline not empty after reset")

endmodule

/* bench/two_level_page_table_walker_core_tb.sv */
// ----------------------------------------------------------------------------
// Two-level page table walker core testbench
// Runs a table of directed translate and response requests, then random walk
// sequences under four idling mixes. Each mix starts with a new directory
// frame. Every accepted request goes through an in-bench walker predictor.
// The bench compares each result field by field with the oldest result due.
// ----------------------------------------------------------------------------
module two_level_page_table_walker_core_tb;
  import tlpw_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 64;
  localparam int REPORT_LINES = 100;

  typedef struct {
    item_t   req;
    int      typed_n;
    result_t typed;
  } dir_row_t;

  logic        clk;
  logic        rst             = 1'b1;
  logic        cfg_valid       = 1'b0;
  logic        cfg_ready;
  logic [19:0] page_dir_frame  = '0;
  logic        in_valid        = 1'b0;
  logic        in_stall;
  logic        action          = 1'b0;
  logic [31:0] virt_addr       = '0;
  logic        access_is_write = 1'b0;
  logic [3:0]  access_len      = '0;
  logic [31:0] mem_read_data   = '0;
  logic        out_valid;
  logic        out_stall       = 1'b0;
  logic [1:0]  result_kind;
  logic [31:0] mem_addr;
  logic [31:0] mem_write_data;
  logic [19:0] phys_frame;
  logic [1:0]  status;
  logic        last;

  // walker predictor state
  walk_phase_t m_phase       = PH_IDLE;
  logic [19:0] m_dir_frame   = '0;
  logic [9:0]  m_dir_index   = '0;
  logic [9:0]  m_table_index = '0;
  logic        m_write_pend  = 1'b0;
  logic [31:0] m_dir_entry   = '0;

  result_t  step_results[$];
  result_t  walk_results_due[$];
  dir_row_t directed_rows[$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int walk_items     = 0;

  two_level_page_table_walker_core u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .page_dir_frame (page_dir_frame),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .virt_addr      (virt_addr),
    .access_is_write(access_is_write),
    .access_len     (access_len),
    .mem_read_data  (mem_read_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_kind    (result_kind),
    .mem_addr       (mem_addr),
    .mem_write_data (mem_write_data),
    .phys_frame     (phys_frame),
    .status         (status),
    .last           (last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("two_level_page_table_walker_core_tb: done, errors");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < REPORT_LINES)
      $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  function automatic result_t walk_result(input logic [1:0] kind, input logic [31:0] addr,
                                          input logic [31:0] data, input logic [19:0] frame,
                                          input logic [1:0] st);
    result_t r;
    r.kind           = kind;
    r.mem_addr       = addr;
    r.mem_write_data = data;
    r.phys_frame     = frame;
    r.status         = st;
    r.last           = 1'b0;
    return r;
  endfunction

  task automatic walk_step(input item_t req);
    logic [31:0] pte;
    logic [31:0] dir_addr;
    logic [31:0] upd;
    result_t     r;
    step_results.delete();
    if (req.action == ACT_TRANSLATE) begin
      if ({1'b0, req.virt_addr[11:0]} + {9'd0, req.access_len} > PAGE_BYTES) begin
        m_phase = PH_IDLE;
        step_results.push_back(walk_result(KIND_DONE, '0, '0, '0, STATUS_CROSS));
      end else begin
        m_dir_index   = req.virt_addr[31:22];
        m_table_index = req.virt_addr[21:12];
        m_write_pend  = req.access_is_write;
        m_phase       = PH_DIR;
        step_results.push_back(walk_result(KIND_READ, {m_dir_frame, m_dir_index, 2'b00},
                                           '0, '0, STATUS_OK));
      end
    end else if (m_phase == PH_DIR) begin
      m_dir_entry = req.mem_read_data;
      if (!req.mem_read_data[BIT_PRESENT]) begin
        m_phase = PH_IDLE;
        step_results.push_back(walk_result(KIND_DONE, '0, '0, '0, STATUS_DIR_ABSENT));
      end else begin
        m_phase = PH_TABLE;
        step_results.push_back(walk_result(KIND_READ,
                                           {req.mem_read_data[31:12], m_table_index, 2'b00},
                                           '0, '0, STATUS_OK));
      end
    end else if (m_phase == PH_TABLE) begin
      pte     = req.mem_read_data;
      m_phase = PH_IDLE;
      if (!pte[BIT_PRESENT]) begin
        step_results.push_back(walk_result(KIND_DONE, '0, '0, '0, STATUS_TABLE_ABSENT));
      end else begin
        dir_addr = {m_dir_frame, m_dir_index, 2'b00};
        if (!m_dir_entry[BIT_ACCESSED]) begin
          upd               = m_dir_entry;
          upd[BIT_ACCESSED] = 1'b1;
          step_results.push_back(walk_result(KIND_WRITE, dir_addr, upd, '0, STATUS_OK));
        end
        if (!pte[BIT_ACCESSED] || (!pte[BIT_DIRTY] && m_write_pend)) begin
          upd               = pte;
          upd[BIT_ACCESSED] = 1'b1;
          if (m_write_pend)
            upd[BIT_DIRTY] = 1'b1;
          step_results.push_back(walk_result(KIND_WRITE,
                                             {m_dir_entry[31:12], m_table_index, 2'b00},
                                             upd, '0, STATUS_OK));
        end
        step_results.push_back(walk_result(KIND_DONE, '0, '0, pte[31:12], STATUS_OK));
      end
    end else begin
      m_phase = PH_IDLE;
    end
    if (step_results.size() > 0) begin
      r      = step_results.pop_back();
      r.last = 1'b1;
      step_results.push_back(r);
    end
  endtask

  // typed_n < 0: take the predicted results; otherwise take typed_n copies of typed
  task automatic offer_request(input item_t req, input int typed_n, input result_t typed);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    action          <= req.action;
    virt_addr       <= req.virt_addr;
    access_is_write <= req.access_is_write;
    access_len      <= req.access_len;
    mem_read_data   <= req.mem_read_data;
    do @(posedge clk); while (in_stall);
    walk_step(req);
    if (step_results.size() > 0)
      walk_items++;
    if (typed_n < 0) begin
      foreach (step_results[i])
        walk_results_due.push_back(step_results[i]);
    end else begin
      for (int i = 0; i < typed_n; i++)
        walk_results_due.push_back(typed);
    end
  endtask

  task automatic offer_predicted(input item_t req);
    result_t none;
    none = '0;
    offer_request(req, -1, none);
  endtask

  task automatic add_row(input logic act, input logic [31:0] va, input logic wr,
                         input logic [3:0] len, input logic [31:0] rd, input int typed_n,
                         input logic [1:0] kind, input logic [31:0] addr,
                         input logic [1:0] st);
    dir_row_t row;
    row.req.action          = act;
    row.req.virt_addr       = va;
    row.req.access_is_write = wr;
    row.req.access_len      = len;
    row.req.mem_read_data   = rd;
    row.typed_n             = typed_n;
    row.typed               = walk_result(kind, addr, '0, '0, st);
    row.typed.last          = 1'b1;
    directed_rows.push_back(row);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (walk_results_due.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_dir_frame(input logic [19:0] frame);
    wait_drained();
    cfg_valid      <= 1'b1;
    page_dir_frame <= frame;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    m_dir_frame  = frame;
  endtask

  function automatic item_t random_translate();
    item_t t;
    t.action          = ACT_TRANSLATE;
    t.virt_addr       = $urandom;
    t.access_is_write = 1'($urandom_range(0, 1));
    t.access_len      = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                    : 4'($urandom_range(1, 8));
    t.mem_read_data   = $urandom;
    if ($urandom_range(0, 7) == 0)
      t.virt_addr[11:0] = 12'hFF0 | 12'($urandom_range(0, 15));
    return t;
  endfunction

  function automatic item_t random_response(input int present_pct);
    item_t t;
    t.action                     = ACT_RESPONSE;
    t.virt_addr                  = $urandom;
    t.access_is_write            = 1'($urandom_range(0, 1));
    t.access_len                 = 4'($urandom_range(0, 15));
    t.mem_read_data              = $urandom;
    t.mem_read_data[BIT_PRESENT] = ($urandom_range(0, 99) < present_pct);
    return t;
  endfunction

  task automatic random_walk();
    int    pick;
    item_t t;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      offer_predicted(random_translate());
      if (pick < 72) begin
        offer_predicted(random_response(88));
        if (pick < 64 && m_phase == PH_TABLE)
          offer_predicted(random_response(88));
      end
    end else if (pick < 90) begin
      offer_predicted(random_response(50));
    end else begin
      t.action          = 1'($urandom_range(0, 1));
      t.virt_addr       = $urandom;
      t.access_is_write = 1'($urandom_range(0, 1));
      t.access_len      = 4'($urandom_range(0, 15));
      t.mem_read_data   = $urandom;
      offer_predicted(t);
    end
  endtask

  // check accepted results, then drive the stall for the next cycle
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (walk_results_due.size() == 0) begin
        report_mismatch("result with nothing due, kind", 32'(result_kind), '0);
      end else begin
        want = walk_results_due.pop_front();
        if (result_kind !== want.kind)
          report_mismatch("result_kind", 32'(result_kind), 32'(want.kind));
        if (mem_addr !== want.mem_addr)
          report_mismatch("mem_addr", mem_addr, want.mem_addr);
        if (mem_write_data !== want.mem_write_data)
          report_mismatch("mem_write_data", mem_write_data, want.mem_write_data);
        if (phys_frame !== want.phys_frame)
          report_mismatch("phys_frame", 32'(phys_frame), 32'(want.phys_frame));
        if (status !== want.status)
          report_mismatch("status", 32'(status), 32'(want.status));
        if (last !== want.last)
          report_mismatch("last", 32'(last), 32'(want.last));
      end
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  initial begin
    logic [19:0] frames[4];
    int          gap_pcts[4];
    int          stall_pcts[4];
    item_t       closer;
    frames     = '{20'hFFFFF, 20'h00000, 20'($urandom), 20'($urandom)};
    gap_pcts   = '{0, 60, 0, 24};
    stall_pcts = '{0, 0, 60, 24};

    add_row(ACT_RESPONSE,  32'h0000_0000, 1'b0, 4'd1,  32'hFFFF_FFFF, 0,
            KIND_DONE, '0, STATUS_OK);
    add_row(ACT_TRANSLATE, 32'h0000_0000, 1'b0, 4'd1,  32'hFFFF_FFFF, 1,
            KIND_READ, 32'h0000_0000, STATUS_OK);
    add_row(ACT_RESPONSE,  32'hFFFF_FFFF, 1'b1, 4'd15, 32'hFFFF_FFFE, 1,
            KIND_DONE, '0, STATUS_DIR_ABSENT);
    add_row(ACT_TRANSLATE, 32'hFFFF_FFFF, 1'b1, 4'd1,  32'h0000_0000, -1,
            KIND_DONE, '0, STATUS_OK);
    add_row(ACT_RESPONSE,  32'h0000_0000, 1'b0, 4'd0,  32'hFFFF_F001, -1,
            KIND_DONE, '0, STATUS_OK);
    add_row(ACT_RESPONSE,  32'h0000_0000, 1'b0, 4'd0,  32'hFFFF_FFFE, 1,
            KIND_DONE, '0, STATUS_TABLE_ABSENT);
    add_row(ACT_TRANSLATE, 32'h0000_0FFF, 1'b0, 4'd2,  32'h0000_0000, 1,
            KIND_DONE, '0, STATUS_CROSS);
    add_row(ACT_TRANSLATE, 32'hFFFF_FFFF, 1'b1, 4'd15, 32'hFFFF_FFFF, 1,
            KIND_DONE, '0, STATUS_CROSS);
    add_row(ACT_TRANSLATE, 32'h0000_0FF8, 1'b1, 4'd8,  32'h0000_0000, -1,
            KIND_DONE, '0, STATUS_OK);
    add_row(ACT_RESPONSE,  32'h0000_0000, 1'b0, 4'd0,  32'h0012_3021, -1,
            KIND_DONE, '0, STATUS_OK);
    add_row(ACT_RESPONSE,  32'h0000_0000, 1'b0, 4'd0,  32'hABCD_E001, -1,
            KIND_DONE, '0, STATUS_OK);
    add_row(ACT_TRANSLATE, 32'h1234_5678, 1'b0, 4'd4,  32'h0000_0000, -1,
            KIND_DONE, '0, STATUS_OK);
    add_row(ACT_RESPONSE,  32'h0000_0000, 1'b0, 4'd0,  32'h0000_1001, -1,
            KIND_DONE, '0, STATUS_OK);
    add_row(ACT_RESPONSE,  32'h0000_0000, 1'b0, 4'd0,  32'hFFFF_FFFF, -1,
            KIND_DONE, '0, STATUS_OK);
    add_row(ACT_TRANSLATE, 32'h0000_0FFF, 1'b0, 4'd0,  32'h0000_0000, -1,
            KIND_DONE, '0, STATUS_OK);
    add_row(ACT_TRANSLATE, 32'h8000_0FF1, 1'b0, 4'd15, 32'h0000_0000, -1,
            KIND_DONE, '0, STATUS_OK);
    add_row(ACT_RESPONSE,  32'h0000_0000, 1'b0, 4'd0,  32'h7000_0003, -1,
            KIND_DONE, '0, STATUS_OK);
    add_row(ACT_RESPONSE,  32'h0000_0000, 1'b0, 4'd0,  32'h5555_5061, -1,
            KIND_DONE, '0, STATUS_OK);
    add_row(ACT_TRANSLATE, 32'hC0DE_B000, 1'b1, 4'd8,  32'h0000_0000, -1,
            KIND_DONE, '0, STATUS_OK);
    add_row(ACT_RESPONSE,  32'h0000_0000, 1'b0, 4'd0,  32'h0040_0001, -1,
            KIND_DONE, '0, STATUS_OK);
    add_row(ACT_RESPONSE,  32'h0000_0000, 1'b0, 4'd0,  32'h0080_0021, -1,
            KIND_DONE, '0, STATUS_OK);
    add_row(ACT_TRANSLATE, 32'h0040_1000, 1'b1, 4'd3,  32'h0000_0000, -1,
            KIND_DONE, '0, STATUS_OK);
    add_row(ACT_RESPONSE,  32'h0000_0000, 1'b0, 4'd0,  32'h0000_0021, -1,
            KIND_DONE, '0, STATUS_OK);
    add_row(ACT_TRANSLATE, 32'hFFFF_FFF2, 1'b0, 4'd15, 32'h0000_0000, 1,
            KIND_DONE, '0, STATUS_CROSS);
    add_row(ACT_RESPONSE,  32'h0000_0000, 1'b0, 4'd0,  32'h0000_0001, 0,
            KIND_DONE, '0, STATUS_OK);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      offer_request(directed_rows[i].req, directed_rows[i].typed_n, directed_rows[i].typed);

    for (int p = 0; p < 4; p++) begin
      set_dir_frame(frames[p]);
      send_gap_pct   = gap_pcts[p];
      recv_stall_pct = stall_pcts[p];
      // hold the output off long enough to back up the input
      if (p == 0)
        hold_left = 150;
      walk_items = 0;
      while (walk_items < PHASE_ITEMS)
        random_walk();
      // drop any walk in progress before the next frame change
      closer                 = random_translate();
      closer.virt_addr[11:0] = 12'hFFF;
      closer.access_len      = 4'd8;
      offer_predicted(closer);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && walk_results_due.size() == 0)
      $display("two_level_page_table_walker_core_tb: done, clean");
    else
      $display("two_level_page_table_walker_core_tb: done, errors");
    $finish;
  end

endmodule
